>>> sv/hs_pkg.sv
// hs_pkg: shared types and constants for the heap sorter unit.
// No dependencies; compiled first.
package hs_pkg;

  localparam int KEY_W = 32;  // width of the key fields on both channels

  typedef enum logic {
    HS_LOAD,
    HS_EMIT
  } hs_state_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;    // insert the incoming key into the sorted chain
    logic shift;  // move the chain one place towards cell 0
  } hs_cell_ctl_t;

endpackage

>>> sv/hs_if.sv
// Channel interfaces for the heap sorter unit: key input and sorted output.
// Depends on hs_pkg for the key width.
interface key_if;
  import hs_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic             last_key;

  modport source (output valid, output key, output last_key, input ready);
  modport sink (input valid, input key, input last_key, output ready);
endinterface

interface sorted_if;
  import hs_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_key;
  logic             last_sorted;
  logic             overflowed;

  modport source (output valid, output sorted_key, output last_sorted,
                  output overflowed, input ready);
  modport sink (input valid, input sorted_key, input last_sorted,
                input overflowed, output ready);
endinterface

>>> sv/heap_sorter_unit.sv
// heap_sorter_unit: top level, a chain of sorting cells under hs_ctrl.
// Depends on hs_pkg, hs_if (key_if, sorted_if), hs_cell and hs_ctrl.
//
//  channel   dir  fields                                  handshake
//  keys      in   key, last_key                           valid/ready
//  sorted    out  sorted_key, last_sorted, overflowed     valid/ready
//  cfg       in   cfg_wr_data (order_descending)          cfg_wr_en only
//
// Loading accepts one key per cycle: each key is inserted into its sorted
// place in the cell chain as it arrives. After the last key the set of
// keys leaves from cell 0, the chain shifting on each result, while no
// key is taken. Stalls on the sorted side hold the chain.
// Reset (rst, synchronous) empties the chain and sets ascending order.
module heap_sorter_unit #(
  parameter int MAX_KEYS = 64,
  parameter int KEY_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  key_if.sink             keys,
  sorted_if.source        sorted
);
  import hs_pkg::*;

  localparam int SW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CW = $clog2(MAX_KEYS + 1);

  hs_cell_ctl_t  ctl;
  logic          desc;
  logic [SW-1:0] new_key;
  logic [SW-1:0] cell_key   [MAX_KEYS];
  logic          cell_valid [MAX_KEYS];
  logic          cell_keep  [MAX_KEYS];

  assign new_key = keys.key[SW-1:0];

  hs_ctrl #(
    .MAX_KEYS (MAX_KEYS),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (keys.valid),
    .in_last     (keys.last_key),
    .out_ready   (sorted.ready),
    .in_ready    (keys.ready),
    .out_valid   (sorted.valid),
    .last_sorted (sorted.last_sorted),
    .overflowed  (sorted.overflowed),
    .desc        (desc),
    .ctl         (ctl)
  );

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    logic          p_keep, p_valid, n_valid;
    logic [SW-1:0] p_key, n_key;

    // cell 0 sees a virtual predecessor that always keeps its place
    if (i == 0) begin : g_head
      assign p_keep  = 1'b1;
      assign p_valid = 1'b0;
      assign p_key   = '0;
    end else begin : g_body
      assign p_keep  = cell_keep[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_key   = cell_key[i-1];
    end

    if (i == MAX_KEYS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_key   = '0;
    end else begin : g_link
      assign n_valid = cell_valid[i+1];
      assign n_key   = cell_key[i+1];
    end

    hs_cell #(
      .SW (SW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .desc       (desc),
      .new_key    (new_key),
      .prev_keep  (p_keep),
      .prev_valid (p_valid),
      .prev_key   (p_key),
      .next_valid (n_valid),
      .next_key   (n_key),
      .keep       (cell_keep[i]),
      .valid      (cell_valid[i]),
      .key        (cell_key[i])
    );
  end

  assign sorted.sorted_key = KEY_W'(cell_key[0]);

endmodule

>>> sv/hs_cell.sv
// hs_cell: one slot of the sorted chain, holding a key and its valid bit.
// Depends on hs_pkg for the command struct.
module hs_cell #(
  parameter int SW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hs_pkg::hs_cell_ctl_t ctl,
  input  logic                 desc,
  input  logic [SW-1:0]        new_key,
  input  logic                 prev_keep,
  input  logic                 prev_valid,
  input  logic [SW-1:0]        prev_key,
  input  logic                 next_valid,
  input  logic [SW-1:0]        next_key,
  output logic                 keep,
  output logic                 valid,
  output logic [SW-1:0]        key
);
  import hs_pkg::*;

  logic          valid_next;
  logic [SW-1:0] key_next;

  // a held key stays put when it belongs ahead of the incoming one
  assign keep = valid && (desc ? (key >= new_key) : (key <= new_key));

  always_comb begin
    valid_next = valid;
    key_next   = key;
    if (ctl.shift) begin
      valid_next = next_valid;
      key_next   = next_key;
    end else if (ctl.ins && !keep) begin
      if (prev_keep) begin
        valid_next = 1'b1;
        key_next   = new_key;
      end else begin
        valid_next = prev_valid;
        key_next   = prev_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

>>> sv/hs_ctrl.sv
// hs_ctrl: load/emit sequencer, key count, overflow flag and order register.
// Depends on hs_pkg for the state type and the cell command struct.
module hs_ctrl #(
  parameter int MAX_KEYS = 64,
  parameter int CW       = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_last,
  input  logic                 out_ready,
  output logic                 in_ready,
  output logic                 out_valid,
  output logic                 last_sorted,
  output logic                 overflowed,
  output logic                 desc,
  output hs_pkg::hs_cell_ctl_t ctl
);
  import hs_pkg::*;

  hs_state_t         state, state_next;
  logic [CW-1:0]     count, count_next;
  logic              dropped, dropped_next;
  logic              acc, full, done;

  assign full = (count == CW'(MAX_KEYS));
  assign acc  = in_valid && in_ready;
  assign done = out_valid && out_ready && (count == CW'(1));

  assign ctl.ins   = acc && !full;
  assign ctl.shift = out_valid && out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      HS_LOAD: if (acc && in_last) state_next = HS_EMIT;
      HS_EMIT: if (done) state_next = HS_LOAD;
      default: state_next = HS_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      HS_LOAD: in_ready = 1'b1;
      HS_EMIT: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign last_sorted = (count == CW'(1));
  assign overflowed  = dropped;

  always_comb begin
    count_next   = count;
    dropped_next = dropped;
    if (ctl.ins) count_next = count + CW'(1);
    if (acc && full) dropped_next = 1'b1;
    if (ctl.shift) count_next = count - CW'(1);
    if (done) dropped_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= HS_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      desc    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      if (cfg_wr_en) desc <= cfg_wr_data;
    end
  end

endmodule

>>> tb/tb_heap_sorter_unit.sv
// Self-checking bench for heap_sorter_unit: keys are loaded in sets, each burst of
// sorted keys is checked against an in-bench sort, under both orders and various stalls.
// Depends on hs_pkg, hs_if (key_if, sorted_if) and the heap_sorter_unit RTL.
module tb_heap_sorter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hs_pkg::*;

  localparam int STORE_DEPTH      = 64;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int MAX_REPORTS      = 10;
  localparam int RANDOM_PER_PHASE = 12;
  localparam int NUM_PHASES       = 5;
  localparam logic ORDER_ASC      = 1'b0;
  localparam logic ORDER_DESC     = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } key_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             ovf;
  } sorted_item_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  key_if    keys_ch ();
  sorted_if sorted_ch ();

  heap_sorter_unit #(
    .MAX_KEYS(STORE_DEPTH),
    .KEY_BITS(KEY_W)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .keys       (keys_ch),
    .sorted     (sorted_ch)
  );

  key_item_t        pending_keys[$];
  sorted_item_t     sorted_due[$];
  logic [KEY_W-1:0] held_keys[STORE_DEPTH];
  int               held_n;
  logic             held_dropped;
  logic             sort_desc;
  int               mismatches = 0;
  int               idle_cycles = 0;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;

  logic        phase_order[NUM_PHASES] = '{ORDER_ASC, ORDER_DESC, ORDER_ASC, ORDER_DESC,
                                           ORDER_ASC};
  int unsigned phase_send[NUM_PHASES]  = '{0, 86, 0, 22, 0};
  int unsigned phase_recv[NUM_PHASES]  = '{0, 0, 86, 22, 0};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $realtime, what);
  endtask

  function automatic void push_key(input logic [KEY_W-1:0] k, input logic last);
    key_item_t it;
    it.key  = k;
    it.last = last;
    pending_keys.push_back(it);
  endfunction

  // extremes, sign boundary and a repeated zero in one set
  function automatic void add_extremes();
    push_key(32'hFFFF_FFFF, 1'b0);
    push_key(32'h0000_0000, 1'b0);
    push_key(32'h8000_0000, 1'b0);
    push_key(32'h7FFF_FFFF, 1'b0);
    push_key(32'h0000_0001, 1'b0);
    push_key(32'hFFFF_FFFE, 1'b0);
    push_key(32'h0000_0000, 1'b1);
  endfunction

  // mixes wide random keys with clustered ones so duplicates and extremes turn up
  function automatic int add_random_set(input int n);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: k = $urandom();
        1: k = $urandom_range(7);
        2: k = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom_range(3);
        default: begin
          k = 32'h1 << $urandom_range(KEY_W - 1);
          if ($urandom_range(1)) k = ~k;
        end
      endcase
      push_key(k, i == n - 1);
    end
    return n;
  endfunction

  // key driver: holds an item until taken, then maybe idles
  always @(posedge clk) begin : key_driver
    key_item_t nxt;
    if (rst) begin
      keys_ch.valid    <= 1'b0;
      keys_ch.key      <= '0;
      keys_ch.last_key <= 1'b0;
    end else if (!keys_ch.valid || keys_ch.ready) begin
      if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_keys.pop_front();
        keys_ch.valid    <= 1'b1;
        keys_ch.key      <= nxt.key;
        keys_ch.last_key <= nxt.last;
      end else begin
        keys_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : sorted_sink
    if (rst) begin
      sorted_ch.ready <= 1'b0;
    end else begin
      sorted_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // checks results first, then folds accepted keys into the expected bursts
  always @(posedge clk) begin : monitor
    sorted_item_t     want;
    logic [KEY_W-1:0] v;
    int               j;
    if (rst) begin
      held_n       = 0;
      held_dropped = 1'b0;
      sort_desc    = ORDER_ASC;
    end else begin
      if (sorted_ch.valid && sorted_ch.ready) begin
        if (sorted_due.size() == 0) begin
          note_mismatch($sformatf("unexpected item: sorted_key %h last_sorted %b overflowed %b",
                                  sorted_ch.sorted_key, sorted_ch.last_sorted,
                                  sorted_ch.overflowed));
        end else begin
          want = sorted_due.pop_front();
          if (sorted_ch.sorted_key !== want.key || sorted_ch.last_sorted !== want.last ||
              sorted_ch.overflowed !== want.ovf) begin
            note_mismatch($sformatf(
                "sorted_key %h last_sorted %b overflowed %b, expected %h %b %b",
                sorted_ch.sorted_key, sorted_ch.last_sorted, sorted_ch.overflowed,
                want.key, want.last, want.ovf));
          end
        end
      end
      if (cfg_wr_en) sort_desc = cfg_wr_data;
      if (keys_ch.valid && keys_ch.ready) begin
        if (held_n < STORE_DEPTH) begin
          held_keys[held_n] = keys_ch.key;
          held_n++;
        end else begin
          held_dropped = 1'b1;
        end
        if (keys_ch.last_key) begin
          // insertion sort is enough for 64 keys; equal keys are indistinguishable
          for (int i = 1; i < held_n; i++) begin
            v = held_keys[i];
            j = i;
            while (j > 0 && (sort_desc ? held_keys[j-1] < v : held_keys[j-1] > v)) begin
              held_keys[j] = held_keys[j-1];
              j--;
            end
            held_keys[j] = v;
          end
          for (int i = 0; i < held_n; i++) begin
            want.key  = held_keys[i];
            want.last = (i == held_n - 1);
            want.ovf  = held_dropped;
            sorted_due.push_back(want);
          end
          held_n       = 0;
          held_dropped = 1'b0;
        end
      end
      if ((keys_ch.valid && keys_ch.ready) || (sorted_ch.valid && sorted_ch.ready) ||
          cfg_wr_en) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int queued;
    int r;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = ORDER_ASC;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= phase_order[ph];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      @(negedge clk);

      if (ph == 0) begin
        add_extremes();
        push_key(32'h0000_0000, 1'b1);  // set of one key
        push_key(32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 4; i++) push_key(32'h5, i == 3);  // all keys equal
        push_key(32'hA5A5_A5A5, 1'b0);
        push_key(32'h5A5A_5A5A, 1'b1);
      end
      if (ph == 1) add_extremes();
      if (ph == 2) void'(add_random_set(STORE_DEPTH));      // store exactly full
      if (ph == 3) void'(add_random_set(STORE_DEPTH + 3));  // overflow, last three keys dropped

      queued = 0;
      while (queued < RANDOM_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 65)      queued += add_random_set($urandom_range(8, 1));
        else if (r < 88) queued += add_random_set($urandom_range(STORE_DEPTH - 1, 9));
        else if (r < 95) queued += add_random_set(STORE_DEPTH);
        else             queued += add_random_set($urandom_range(STORE_DEPTH + 6,
                                                                 STORE_DEPTH + 1));
      end

      do @(negedge clk);
      while (pending_keys.size() != 0 || keys_ch.valid || sorted_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
